[src/tfv_pkg.sv]
// Shared types, constants and helper functions for the telecommand frame validator.
// No dependencies; used by telecommand_frame_validator_top.
`timescale 1ns / 1ps

package tfv_pkg;

	// frame geometry
	localparam int MAX_FRAME = 64;
	localparam int MIN_FRAME = 4;
	localparam int OVERHEAD  = 4;
	localparam int CNT_W     = 7;  // holds MAX_FRAME + 1
	localparam int NUM_OPS   = 6;
	localparam int ROW_W     = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// verdict codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_LONG     = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_CRC      = 3'd4;
	localparam logic [2:0] ST_OPCODE   = 3'd5;
	localparam logic [2:0] ST_PLEN     = 3'd6;
	localparam logic [2:0] ST_RANGE    = 3'd7;

	// register indexes
	localparam logic [2:0] REG_CODE_RESET  = 3'd0;
	localparam logic [2:0] REG_CODE_EXIT   = 3'd1;
	localparam logic [2:0] REG_CODE_SETCFG = 3'd2;
	localparam logic [2:0] REG_CODE_SEND   = 3'd3;
	localparam logic [2:0] REG_CODE_ACT    = 3'd4;
	localparam logic [2:0] REG_CODE_BEACON = 3'd5;
	localparam logic [2:0] REG_BEACON_MIN  = 3'd6;
	localparam logic [2:0] REG_BEACON_MAX  = 3'd7;

	localparam logic [ROW_W-1:0] BEACON_ROW = 3'd5;
	localparam logic [ROW_W-1:0] NO_ROW     = 3'd6;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  cmd_opcode;
		logic [5:0]  pay_len;
		logic [31:0] param_value;
		logic [31:0] accepted_count;
		logic [31:0] rejected_count;
		logic [31:0] crc_reject_count;
		logic [31:0] malformed_count;
		logic [31:0] opcode_reject_count;
		logic [31:0] range_reject_count;
	} out_word_t;

	// one byte of CRC-16/CCITT-FALSE, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] pay_min(input logic [ROW_W-1:0] row);
		case (row)
			3'd2:    return 8'd1;
			3'd5:    return 8'd4;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] pay_max(input logic [ROW_W-1:0] row);
		case (row)
			3'd2:    return 8'd32;
			3'd3:    return 8'd8;
			3'd5:    return 8'd4;
			default: return 8'd0;
		endcase
	endfunction

endpackage

[src/telecommand_frame_validator_top.sv]
// Telecommand frame validator: byte-wide frame intake, CRC, length/opcode/parameter checks.
// Depends on tfv_pkg (types, codes, CRC step and payload bound tables).
//
// channel  | direction | handshake              | word
// ---------+-----------+------------------------+-------------------------------
// in       | input     | in_valid / in_ready    | tfv_pkg::in_word_t (byte, end)
// out      | output    | out_valid / out_ready  | tfv_pkg::out_word_t (verdict)
// apb      | input     | psel/penable/pwrite    | 8 registers at 4*i, 32-bit
//
// One byte per cycle while in_ready is high. A final byte is captured in the frame snapshot
// when it is accepted; the checks run combinationally from there and the verdict register
// loads once out_valid is low or out_ready is high. Non-final bytes give no word. Reset
// clears frame state, counters and the config to defaults. in_ready drops only while a
// finished frame waits in the check stage behind a stalled verdict register.
`timescale 1ns / 1ps

module telecommand_frame_validator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tfv_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tfv_pkg::out_word_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration
	logic [7:0]  op_code_q [tfv_pkg::NUM_OPS];
	logic [31:0] beacon_min_q, beacon_max_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	// frame state
	logic [15:0]              crc_q;
	logic [tfv_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]               opcode_q, len_q, d0_q, d1_q;
	logic [31:0]              pshift_q;

	// completed frame
	logic                     valid_s1;
	logic [15:0]              crc_s1;
	logic [tfv_pkg::CNT_W-1:0] cnt_s1;
	logic [7:0]               opcode_s1, len_s1, d0_s1, d1_s1;
	logic [31:0]              pshift_s1;

	// verdict and counters
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  opcode_q2;
	logic [5:0]  plen_q;
	logic [31:0] pval_q;
	logic [31:0] acc_q, rej_q, crcr_q, mal_q, opc_q, rng_q;

	logic in_fire, out_free, adv;

	// next frame state
	logic [15:0]              crc_nx;
	logic [tfv_pkg::CNT_W-1:0] cnt_nx;
	logic [7:0]               opcode_nx, len_nx;
	logic [31:0]              pshift_nx;

	// check stage
	logic [2:0]                status_c;
	logic [tfv_pkg::ROW_W-1:0] row_c;
	logic [31:0]               pval_c;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			tfv_pkg::REG_CODE_RESET:  prdata = {24'd0, op_code_q[0]};
			tfv_pkg::REG_CODE_EXIT:   prdata = {24'd0, op_code_q[1]};
			tfv_pkg::REG_CODE_SETCFG: prdata = {24'd0, op_code_q[2]};
			tfv_pkg::REG_CODE_SEND:   prdata = {24'd0, op_code_q[3]};
			tfv_pkg::REG_CODE_ACT:    prdata = {24'd0, op_code_q[4]};
			tfv_pkg::REG_CODE_BEACON: prdata = {24'd0, op_code_q[5]};
			tfv_pkg::REG_BEACON_MIN:  prdata = beacon_min_q;
			tfv_pkg::REG_BEACON_MAX:  prdata = beacon_max_q;
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tfv_pkg::NUM_OPS; i++) op_code_q[i] <= 8'(i + 1);
			beacon_min_q <= 32'd1000;
			beacon_max_q <= 32'd3600000;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				tfv_pkg::REG_CODE_RESET:  op_code_q[0] <= pwdata[7:0];
				tfv_pkg::REG_CODE_EXIT:   op_code_q[1] <= pwdata[7:0];
				tfv_pkg::REG_CODE_SETCFG: op_code_q[2] <= pwdata[7:0];
				tfv_pkg::REG_CODE_SEND:   op_code_q[3] <= pwdata[7:0];
				tfv_pkg::REG_CODE_ACT:    op_code_q[4] <= pwdata[7:0];
				tfv_pkg::REG_CODE_BEACON: op_code_q[5] <= pwdata[7:0];
				tfv_pkg::REG_BEACON_MIN:  beacon_min_q <= pwdata;
				tfv_pkg::REG_BEACON_MAX:  beacon_max_q <= pwdata;
				default: ;
			endcase
		end
	end

	// ---------------- byte intake ----------------
	// CRC lags the stream by two bytes so the trailer never enters it
	always_comb begin
		crc_nx    = (cnt_q >= tfv_pkg::CNT_W'(2)) ? tfv_pkg::crc_byte(crc_q, d0_q) : crc_q;
		opcode_nx = (cnt_q == '0) ? in_data.frame_byte : opcode_q;
		len_nx    = (cnt_q == tfv_pkg::CNT_W'(1)) ? in_data.frame_byte : len_q;
		pshift_nx = (cnt_q >= tfv_pkg::CNT_W'(2) && cnt_q <= tfv_pkg::CNT_W'(5)) ?
			{pshift_q[23:0], in_data.frame_byte} : pshift_q;
		cnt_nx    = (cnt_q <= tfv_pkg::CNT_W'(tfv_pkg::MAX_FRAME)) ?
			cnt_q + tfv_pkg::CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= tfv_pkg::CRC_INIT;
			cnt_q    <= '0;
			opcode_q <= '0;
			len_q    <= '0;
			d0_q     <= '0;
			d1_q     <= '0;
			pshift_q <= '0;
		end else if (in_fire) begin
			if (in_data.frame_end) begin
				crc_q    <= tfv_pkg::CRC_INIT;
				cnt_q    <= '0;
				opcode_q <= '0;
				len_q    <= '0;
				d0_q     <= '0;
				d1_q     <= '0;
				pshift_q <= '0;
			end else begin
				crc_q    <= crc_nx;
				cnt_q    <= cnt_nx;
				opcode_q <= opcode_nx;
				len_q    <= len_nx;
				d0_q     <= d1_q;
				d1_q     <= in_data.frame_byte;
				pshift_q <= pshift_nx;
			end
		end
	end

	// snapshot of a finished frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire && in_data.frame_end) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data.frame_end) begin
			crc_s1    <= crc_nx;
			cnt_s1    <= cnt_nx;
			opcode_s1 <= opcode_nx;
			len_s1    <= len_nx;
			d0_s1     <= d1_q;
			d1_s1     <= in_data.frame_byte;
			pshift_s1 <= pshift_nx;
		end
	end

	// ---------------- checks ----------------
	always_comb begin
		row_c = tfv_pkg::NO_ROW;
		for (int i = tfv_pkg::NUM_OPS - 1; i >= 0; i--) begin
			if (op_code_q[i] == opcode_s1) row_c = tfv_pkg::ROW_W'(i);
		end
	end

	always_comb begin
		status_c = tfv_pkg::ST_OK;
		pval_c   = '0;
		if (cnt_s1 < tfv_pkg::CNT_W'(tfv_pkg::MIN_FRAME)) begin
			status_c = tfv_pkg::ST_SHORT;
		end else if (cnt_s1 > tfv_pkg::CNT_W'(tfv_pkg::MAX_FRAME)) begin
			status_c = tfv_pkg::ST_LONG;
		end else if (len_s1 > 8'(tfv_pkg::MAX_FRAME - tfv_pkg::OVERHEAD)) begin
			status_c = tfv_pkg::ST_LONG;
		end else if ({1'b0, len_s1} + 9'(tfv_pkg::OVERHEAD) != {2'b00, cnt_s1}) begin
			status_c = tfv_pkg::ST_MISMATCH;
		end else if (crc_s1 != {d0_s1, d1_s1}) begin
			status_c = tfv_pkg::ST_CRC;
		end else if (row_c == tfv_pkg::NO_ROW) begin
			status_c = tfv_pkg::ST_OPCODE;
		end else if (len_s1 < tfv_pkg::pay_min(row_c) || len_s1 > tfv_pkg::pay_max(row_c)) begin
			status_c = tfv_pkg::ST_PLEN;
		end else if (row_c == tfv_pkg::BEACON_ROW) begin
			pval_c = pshift_s1;
			// zero means "keep current interval" and is always allowed
			if (pshift_s1 != 32'd0 &&
				(pshift_s1 < beacon_min_q || pshift_s1 > beacon_max_q))
				status_c = tfv_pkg::ST_RANGE;
		end
	end

	// ---------------- verdict register and counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			rej_q       <= '0;
			crcr_q      <= '0;
			mal_q       <= '0;
			opc_q       <= '0;
			rng_q       <= '0;
		end else begin
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (adv) begin
				case (status_c) inside
					tfv_pkg::ST_OK:     acc_q <= acc_q + 32'd1;
					tfv_pkg::ST_CRC:    crcr_q <= crcr_q + 32'd1;
					tfv_pkg::ST_OPCODE: opc_q <= opc_q + 32'd1;
					tfv_pkg::ST_PLEN, tfv_pkg::ST_RANGE: rng_q <= rng_q + 32'd1;
					default:            mal_q <= mal_q + 32'd1;
				endcase
				if (status_c != tfv_pkg::ST_OK) rej_q <= rej_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q  <= status_c;
			opcode_q2 <= opcode_s1;
			plen_q    <= (status_c == tfv_pkg::ST_OK) ? len_s1[5:0] : 6'd0;
			pval_q    <= pval_c;
		end
	end

	assign out_valid                    = out_valid_q;
	assign out_data.status              = status_q;
	assign out_data.cmd_opcode          = opcode_q2;
	assign out_data.pay_len             = plen_q;
	assign out_data.param_value         = pval_q;
	assign out_data.accepted_count      = acc_q;
	assign out_data.rejected_count      = rej_q;
	assign out_data.crc_reject_count    = crcr_q;
	assign out_data.malformed_count     = mal_q;
	assign out_data.opcode_reject_count = opc_q;
	assign out_data.range_reject_count  = rng_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tfv_pkg::CNT_W'(tfv_pkg::MAX_FRAME + 1))
		else $error("byte count past saturation");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.frame_end) |=> (cnt_q == '0 && crc_q == tfv_pkg::CRC_INIT))
		else $error("frame state not cleared after final byte");

	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (32'(acc_q + rej_q) == 32'($past(acc_q) + $past(rej_q) + 32'd1)))
		else $error("verdict did not bump exactly one of accepted/rejected");

	a_plen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != tfv_pkg::ST_OK) |-> plen_q == 6'd0)
		else $error("payload length reported on a rejected frame");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |-> !in_ready)
		else $error("intake open while finished frame is blocked");
`endif

endmodule

[tb/tb_telecommand_frame_validator_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for telecommand_frame_validator_top: queued frame bytes, a byte-level
// verdict predictor, randomized idling on both channels and APB register phases.
// Depends on tfv_pkg and telecommand_frame_validator_top.

module tb_telecommand_frame_validator_top;

	localparam logic [15:0] CCITT_POLY = 16'h1021;
	localparam logic [15:0] CCITT_SEED = 16'hFFFF;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tfv_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tfv_pkg::out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// stimulus and expectations
	tfv_pkg::in_word_t byte_backlog[$];
	tfv_pkg::out_word_t verdicts_due[$];
	int bytes_queued = 0;
	int unsigned idle_in_pct = 0;
	int unsigned stall_out_pct = 0;
	int fails = 0;
	int quiet = 0;

	// register shadow
	logic [7:0] cfg_op [tfv_pkg::NUM_OPS];
	logic [31:0] cfg_bmin;
	logic [31:0] cfg_bmax;

	// frame tracker
	logic [15:0] crc_run;
	int seen;
	logic [7:0] op_hold;
	logic [7:0] len_hold;
	logic [7:0] lag0;
	logic [7:0] lag1;
	logic [31:0] param_acc;
	logic [31:0] n_acc, n_rej, n_crc, n_mal, n_opc, n_rng;

	telecommand_frame_validator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bit-serial CRC-16/CCITT-FALSE step, MSB first
	function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] c;
		logic fb;
		c = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ data[k];
			c = {c[14:0], 1'b0};
			if (fb) c = c ^ CCITT_POLY;
		end
		return c;
	endfunction

	function automatic logic [7:0] row_floor(input logic [2:0] row);
		case (row)
			tfv_pkg::REG_CODE_SETCFG: return 8'd1;
			tfv_pkg::REG_CODE_BEACON: return 8'd4;
			default:                  return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] row_ceil(input logic [2:0] row);
		case (row)
			tfv_pkg::REG_CODE_SETCFG: return 8'd32;
			tfv_pkg::REG_CODE_SEND:   return 8'd8;
			tfv_pkg::REG_CODE_BEACON: return 8'd4;
			default:                  return 8'd0;
		endcase
	endfunction

	task automatic clear_frame_model();
		crc_run = CCITT_SEED;
		seen = 0;
		op_hold = '0;
		len_hold = '0;
		lag0 = '0;
		lag1 = '0;
		param_acc = '0;
	endtask

	// CRC trails the stream by two bytes; the trailer sits in lag0/lag1 at the last byte
	task automatic absorb_byte(input tfv_pkg::in_word_t w);
		logic [2:0] verdict;
		logic [2:0] row;
		logic [31:0] pval;
		tfv_pkg::out_word_t due;
		if (seen >= 2) crc_run = crc_next(crc_run, lag0);
		lag0 = lag1;
		lag1 = w.frame_byte;
		if (seen == 0) op_hold = w.frame_byte;
		else if (seen == 1) len_hold = w.frame_byte;
		else if (seen <= 5) param_acc = {param_acc[23:0], w.frame_byte};
		if (seen <= tfv_pkg::MAX_FRAME) seen++;
		if (w.frame_end) begin
			verdict = tfv_pkg::ST_OK;
			row = tfv_pkg::NO_ROW;
			pval = '0;
			if (seen < tfv_pkg::MIN_FRAME) verdict = tfv_pkg::ST_SHORT;
			else if (seen > tfv_pkg::MAX_FRAME) verdict = tfv_pkg::ST_LONG;
			else if (int'(len_hold) > tfv_pkg::MAX_FRAME - tfv_pkg::OVERHEAD)
				verdict = tfv_pkg::ST_LONG;
			else if (int'(len_hold) + tfv_pkg::OVERHEAD != seen)
				verdict = tfv_pkg::ST_MISMATCH;
			else if (crc_run != {lag0, lag1}) verdict = tfv_pkg::ST_CRC;
			else begin
				// scan downward so the lowest matching register wins
				for (int i = tfv_pkg::NUM_OPS - 1; i >= 0; i--)
					if (cfg_op[i] == op_hold) row = 3'(i);
				if (row == tfv_pkg::NO_ROW) verdict = tfv_pkg::ST_OPCODE;
				else if (len_hold < row_floor(row) || len_hold > row_ceil(row))
					verdict = tfv_pkg::ST_PLEN;
				else if (row == tfv_pkg::REG_CODE_BEACON) begin
					pval = param_acc;
					if (pval != 0 && (pval < cfg_bmin || pval > cfg_bmax))
						verdict = tfv_pkg::ST_RANGE;
				end
			end
			case (verdict) inside
				tfv_pkg::ST_OK:                      n_acc++;
				tfv_pkg::ST_CRC:                     n_crc++;
				tfv_pkg::ST_OPCODE:                  n_opc++;
				tfv_pkg::ST_PLEN, tfv_pkg::ST_RANGE: n_rng++;
				default:                             n_mal++;
			endcase
			if (verdict != tfv_pkg::ST_OK) n_rej++;
			due.status = verdict;
			due.cmd_opcode = op_hold;
			due.pay_len = (verdict == tfv_pkg::ST_OK) ? len_hold[5:0] : 6'd0;
			due.param_value = pval;
			due.accepted_count = n_acc;
			due.rejected_count = n_rej;
			due.crc_reject_count = n_crc;
			due.malformed_count = n_mal;
			due.opcode_reject_count = n_opc;
			due.range_reject_count = n_rng;
			verdicts_due.push_back(due);
			clear_frame_model();
		end
	endtask

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= 10)
				$display("mismatch %s: expected 0x%08h, got 0x%08h", name, want, got);
		end
	endtask

	task automatic check_verdict(input tfv_pkg::out_word_t want,
			input tfv_pkg::out_word_t got);
		field_check("status", 32'(want.status), 32'(got.status));
		field_check("cmd_opcode", 32'(want.cmd_opcode), 32'(got.cmd_opcode));
		field_check("pay_len", 32'(want.pay_len), 32'(got.pay_len));
		field_check("param_value", want.param_value, got.param_value);
		field_check("accepted_count", want.accepted_count, got.accepted_count);
		field_check("rejected_count", want.rejected_count, got.rejected_count);
		field_check("crc_reject_count", want.crc_reject_count, got.crc_reject_count);
		field_check("malformed_count", want.malformed_count, got.malformed_count);
		field_check("opcode_reject_count", want.opcode_reject_count,
			got.opcode_reject_count);
		field_check("range_reject_count", want.range_reject_count, got.range_reject_count);
	endtask

	// byte driver; prediction runs on every accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			clear_frame_model();
			n_acc = '0;
			n_rej = '0;
			n_crc = '0;
			n_mal = '0;
			n_opc = '0;
			n_rng = '0;
		end else begin
			if (in_valid && in_ready) absorb_byte(in_data);
			if (!in_valid || in_ready) begin
				if (byte_backlog.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
					in_data <= byte_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected verdict word: status %0d opcode 0x%02h",
							out_data.status, out_data.cmd_opcode);
				end else begin
					check_verdict(verdicts_due.pop_front(), out_data);
				end
			end
			out_ready <= ($urandom_range(99) >= stall_out_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("telecommand_frame_validator_top regression: fail");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tfv_pkg::REG_BEACON_MIN: cfg_bmin = val;
			tfv_pkg::REG_BEACON_MAX: cfg_bmax = val;
			default:                 cfg_op[idx] = val[7:0];
		endcase
	endtask

	task automatic program_table(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4,
			input logic [7:0] c5, input logic [31:0] lo, input logic [31:0] hi);
		reg_write(tfv_pkg::REG_CODE_RESET, 32'(c0));
		reg_write(tfv_pkg::REG_CODE_EXIT, 32'(c1));
		reg_write(tfv_pkg::REG_CODE_SETCFG, 32'(c2));
		reg_write(tfv_pkg::REG_CODE_SEND, 32'(c3));
		reg_write(tfv_pkg::REG_CODE_ACT, 32'(c4));
		reg_write(tfv_pkg::REG_CODE_BEACON, 32'(c5));
		reg_write(tfv_pkg::REG_BEACON_MIN, lo);
		reg_write(tfv_pkg::REG_BEACON_MAX, hi);
	endtask

	// opcode, length, body (first four body bytes carry param), CRC trailer
	task automatic push_frame(input logic [7:0] op, input logic [7:0] dlen, input int nbody,
			input bit corrupt, input logic [31:0] param);
		logic [7:0] body [$];
		logic [15:0] sum;
		body = {op, dlen};
		for (int i = 0; i < nbody; i++)
			body.push_back(i < 4 ? param[31 - 8*i -: 8] : 8'($urandom));
		sum = CCITT_SEED;
		foreach (body[i]) sum = crc_next(sum, body[i]);
		if (corrupt) sum = sum ^ (16'd1 << $urandom_range(15));
		body.push_back(sum[15:8]);
		body.push_back(sum[7:0]);
		foreach (body[i])
			byte_backlog.push_back('{frame_byte: body[i], frame_end: i == body.size() - 1});
		bytes_queued += body.size();
	endtask

	task automatic push_short(input int n, input logic [7:0] lead);
		for (int i = 0; i < n; i++)
			byte_backlog.push_back('{frame_byte: (i == 0) ? lead : 8'($urandom),
				frame_end: i == n - 1});
		bytes_queued += n;
	endtask

	function automatic logic [31:0] pick_param();
		longint span;
		case ($urandom_range(7))
			0: return 32'd0;
			1: return cfg_bmin;
			2: return cfg_bmax;
			3: return cfg_bmin - 32'd1;
			4: return cfg_bmax + 32'd1;
			5, 6: begin
				span = longint'(cfg_bmax) - longint'(cfg_bmin) + 1;
				if (span <= 0) return $urandom;
				return cfg_bmin + 32'(longint'($urandom) % span);
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic random_frames(input int budget);
		int stop;
		int r;
		int dlen;
		int nbody;
		logic [2:0] row;
		logic [7:0] op;
		stop = bytes_queued + budget;
		while (bytes_queued < stop) begin
			r = $urandom_range(99);
			row = 3'($urandom_range(tfv_pkg::NUM_OPS - 1));
			op = ($urandom_range(9) == 0) ? 8'($urandom) : cfg_op[row];
			if (r < 80) begin
				// mostly well-formed, the tail of this band with a broken trailer
				if ($urandom_range(4) == 0) dlen = $urandom_range(12);
				else dlen = $urandom_range(row_ceil(row), row_floor(row));
				push_frame(op, 8'(dlen), dlen, r >= 70, pick_param());
			end else if (r < 88) begin
				dlen = $urandom_range(20);
				if (dlen >= 3 && $urandom_range(1) == 1) nbody = dlen - $urandom_range(3, 1);
				else nbody = dlen + $urandom_range(3, 1);
				push_frame(op, 8'(dlen), nbody, 1'b0, pick_param());
			end else if (r < 94) begin
				push_short($urandom_range(3, 1), 8'($urandom));
			end else if (r < 97) begin
				push_frame(op, 8'($urandom_range(255, 61)), $urandom_range(8), 1'b0, $urandom);
			end else begin
				push_frame(op, 8'($urandom), $urandom_range(75, 61), 1'b0, $urandom);
			end
		end
	endtask

	// sender holds off until the block has nothing left in flight
	task automatic drain();
		while (byte_backlog.size() > 0 || in_valid || verdicts_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < tfv_pkg::NUM_OPS; i++) cfg_op[i] = 8'(i + 1);
		cfg_bmin = 32'd1000;
		cfg_bmax = 32'd3600000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames on the reset table
		push_short(1, 8'hFF);
		push_short(3, 8'h00);
		push_frame(cfg_op[tfv_pkg::REG_CODE_RESET], 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_EXIT], 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd1, 1, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd32, 32, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd33, 33, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'd8, 8, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'd9, 9, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_ACT], 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_ACT], 8'd1, 1, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'd1000);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'd999);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'd3600000);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'd3600001);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd4, 4, 1'b0, 32'hFFFF_FFFF);
		push_frame(cfg_op[tfv_pkg::REG_CODE_BEACON], 8'd3, 3, 1'b0, $urandom);
		push_frame(8'h00, 8'd0, 0, 1'b0, 32'd0);
		push_frame(8'hFF, 8'd0, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_RESET], 8'd0, 0, 1'b1, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'd2, 3, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd61, 0, 1'b0, 32'd0);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SETCFG], 8'd255, 2, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'd60, 60, 1'b0, $urandom);
		push_frame(cfg_op[tfv_pkg::REG_CODE_SEND], 8'h4A, 70, 1'b0, $urandom);
		drain();

		random_frames(PHASE_BYTES);
		drain();

		// extreme opcodes, widest beacon window
		program_table(8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC3, 8'h3C, 32'h0, 32'hFFFF_FFFF);
		idle_in_pct = 50;
		random_frames(PHASE_BYTES);
		drain();

		// aliased opcodes resolve to the lowest register; single-value window at the top
		program_table(8'h21, 8'h42, 8'h42, 8'h42, 8'h21, 8'h99, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		idle_in_pct = 0;
		stall_out_pct = 50;
		random_frames(PHASE_BYTES);
		drain();

		// inverted window: every nonzero beacon value is out of range
		program_table(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 32'h0001_0000, 32'h0000_00FF);
		idle_in_pct = 20;
		stall_out_pct = 20;
		random_frames(PHASE_BYTES);
		drain();

		if (fails == 0 && verdicts_due.size() == 0)
			$display("telecommand_frame_validator_top regression: pass");
		else
			$display("telecommand_frame_validator_top regression: fail");
		$finish;
	end

endmodule

[filelist.f]
src/tfv_pkg.sv
src/telecommand_frame_validator_top.sv
tb/tb_telecommand_frame_validator_top.sv
